@@ design/afp_pkg.sv @@
`default_nettype none
package afp_pkg;

    localparam logic [9:0]  DEFAULT_FPS   = 10'd60;
    localparam logic [9:0]  DEEP_IDLE_FPS = 10'd5;
    localparam logic [9:0]  UNFOCUSED_FPS = 10'd5;
    localparam logic [31:0] MS_PER_SEC    = 32'd1000;
    localparam logic [31:0] DEEP_GRACE_MS = 32'd20000;
    localparam logic [31:0] SLOW_REACT_MS = 32'd5000;
    localparam logic [5:0]  CHUNK_UNFOCUSED = 6'd50;
    localparam logic [5:0]  CHUNK_SLOW      = 6'd33;
    localparam logic [5:0]  CHUNK_FAST      = 6'd16;

    // Command codes.
    localparam logic [2:0] CMD_MARK     = 3'd0;
    localparam logic [2:0] CMD_ACTIVITY = 3'd1;
    localparam logic [2:0] CMD_PRESENT  = 3'd2;
    localparam logic [2:0] CMD_THROTTLE = 3'd3;
    localparam logic [2:0] CMD_NAP      = 3'd4;

    // Action codes.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SLEEP = 2'd1;
    localparam logic [1:0] ACT_DONE  = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_NOMINAL = 2'd0;
    localparam logic [1:0] REG_CAP     = 2'd1;
    localparam logic [1:0] REG_IDLE    = 2'd2;
    localparam logic [1:0] REG_GRACE   = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] now_ms;
        logic        window_active;
        logic        event_pending;
    } afp_in_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  sleep_ms;
        logic [9:0]  target_fps;
        logic [31:0] busy_per_sec;
    } afp_out_t;

    typedef struct packed {
        logic [9:0]  nominal_fps;
        logic [9:0]  fps_cap;
        logic [9:0]  idle_fps;
        logic [15:0] idle_grace_ms;
    } afp_cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input beat and run the simple commands
        logic thr_prep;  // throttle: window update and rate choice
        logic div_start; // start both divisions
        logic thr_fin;   // throttle: commit budgets and form the result
        logic nap;       // nap check result
        logic out_load;  // the result is complete
    } afp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [2:0] command;
        logic       div_done;
    } afp_stat_t;

endpackage
`default_nettype wire

@@ design/afp_div.sv @@
`default_nettype none
// Restoring divider for 1000 / d, one quotient bit per cycle.
module afp_div
    import afp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [9:0] divisor,
    output logic            done,
    output logic [9:0]      quotient
);
    logic [9:0]  q_reg, q_next;
    logic [10:0] rem_reg, rem_next;
    logic [9:0]  d_reg, d_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [10:0] trial;

    assign quotient = q_reg;
    assign done = busy_reg && (cnt_reg == 4'd0);

    // Shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[9:0], q_reg[9]};
        if (start)
        begin
            q_next = MS_PER_SEC[9:0];
            rem_next = 11'd0;
            d_next = divisor;
            cnt_next = 4'd10;
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg != 4'd0)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next = {q_reg[8:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[8:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
    end
endmodule
`default_nettype wire

@@ design/afp_ctrl.sv @@
`default_nettype none
// Sequencer for one beat: capture, throttle steps, nap check, result.
module afp_ctrl
    import afp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic      out_stall,
    output logic           out_valid,
    input  wire afp_stat_t stat,
    output afp_cmd_t       cmd
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DISP  = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_DIVS  = 7'b0001000,
        ST_DIVW  = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   out_free;

    assign out_valid = ovalid_reg;
    assign in_stall = (state_reg != ST_IDLE);
    // The output register frees up when empty or taken this cycle.
    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        ovalid_next = ovalid_reg;
        cmd = '0;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (stat.command == CMD_THROTTLE)
                    state_next = ST_PREP;
                else
                begin
                    cmd.nap = (stat.command == CMD_NAP);
                    state_next = ST_OUT;
                end
            end
            ST_PREP:
            begin
                cmd.thr_prep = 1'b1;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.thr_fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // A result is only loaded when the output register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken beat");
    // Division is waited on only after it was started.
    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVW) |-> ($past(state_reg) == ST_DIVS
            || $past(state_reg) == ST_DIVW))
        else $error("division wait without start");
    // A beat is accepted only in idle, and then the sequencer leaves idle.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DISP))
        else $error("accepted beat not dispatched");
endmodule
`default_nettype wire

@@ design/afp_dp.sv @@
`default_nettype none
// Pacer state, rate choice, budgets and nap chunking.
module afp_dp
    import afp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire afp_in_t  in_data,
    input  wire afp_cfg_t cfg,
    input  wire afp_cmd_t cmd,
    output afp_stat_t     stat,
    output afp_out_t      out_data
);
    afp_in_t     beat_reg;
    logic [31:0] frame_start_reg, last_activity_reg, last_present_reg;
    logic [31:0] busy_accum_reg, window_start_reg, busy_last_reg;
    logic [9:0]  chosen_fps_reg, soft_budget_reg;
    logic [31:0] throttle_time_reg;
    logic        deep_idle_reg, soft_phase_reg;
    logic [9:0]  base_reg, target_reg;
    logic        deep_reg;
    logic [1:0]  action_reg;
    logic [9:0]  sleep_reg;
    afp_out_t    out_reg;

    logic [31:0] now;
    logic [31:0] elapsed, since_act, since_pres, since_win, busy_sum;
    logic [9:0]  nom, base_raw, base_c, target_raw;
    logic        deep_c;
    logic        hard_done, soft_done;
    logic [9:0]  hard_q, soft_q;
    logic [9:0]  nap_rem;
    logic [5:0]  chunk;
    logic [9:0]  nap_sleep;

    assign now = beat_reg.now_ms;
    assign elapsed = now - frame_start_reg;
    assign since_act = now - last_activity_reg;
    assign since_pres = now - last_present_reg;
    assign since_win = now - window_start_reg;
    assign busy_sum = busy_accum_reg + elapsed;

    // Base rate and target rate selection.
    always_comb
    begin
        nom = (cfg.nominal_fps == 10'd0) ? DEFAULT_FPS : cfg.nominal_fps;
        base_raw = (nom < cfg.fps_cap) ? nom : cfg.fps_cap;
        base_c = (base_raw == 10'd0) ? 10'd1 : base_raw;
        target_raw = base_c;
        deep_c = 1'b0;
        if (!beat_reg.window_active)
            target_raw = UNFOCUSED_FPS;
        else if (since_act > {16'd0, cfg.idle_grace_ms})
        begin
            target_raw = cfg.idle_fps;
            if (since_act > DEEP_GRACE_MS && last_present_reg != 32'd0
                && since_pres > DEEP_GRACE_MS)
            begin
                target_raw = DEEP_IDLE_FPS;
                deep_c = 1'b1;
            end
        end
        if (target_raw == 10'd0)
            target_raw = 10'd1;
    end

    afp_div u_div_hard (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .divisor(base_reg),
        .done(hard_done), .quotient(hard_q)
    );
    afp_div u_div_soft (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .divisor(target_reg),
        .done(soft_done), .quotient(soft_q)
    );

    assign stat.command = beat_reg.command;
    assign stat.div_done = hard_done && soft_done;

    // Nap chunk rule; the remainder fits 10 bits since elapsed < soft budget.
    always_comb
    begin
        nap_rem = soft_budget_reg - elapsed[9:0];
        if (!beat_reg.window_active)
            chunk = CHUNK_UNFOCUSED;
        else if (deep_idle_reg
                 || (throttle_time_reg - last_activity_reg) > SLOW_REACT_MS)
            chunk = CHUNK_SLOW;
        else
            chunk = CHUNK_FAST;
        if (nap_rem > {3'd0, chunk, 1'b0})
            nap_sleep = nap_rem - {4'd0, chunk};
        else
            nap_sleep = (nap_rem < {4'd0, chunk}) ? nap_rem : {4'd0, chunk};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= '0;
            last_activity_reg <= '0;
            last_present_reg <= '0;
            busy_accum_reg <= '0;
            window_start_reg <= '0;
            busy_last_reg <= '0;
            chosen_fps_reg <= DEFAULT_FPS;
            soft_budget_reg <= '0;
            throttle_time_reg <= '0;
            deep_idle_reg <= 1'b0;
            soft_phase_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                case (in_data.command)
                    CMD_MARK:     frame_start_reg <= in_data.now_ms;
                    CMD_ACTIVITY: last_activity_reg <= in_data.now_ms;
                    CMD_PRESENT:  last_present_reg <= in_data.now_ms;
                    default:      ;
                endcase
            end
            if (cmd.thr_prep)
            begin
                if (since_win >= MS_PER_SEC)
                begin
                    busy_last_reg <= busy_sum;
                    busy_accum_reg <= '0;
                    window_start_reg <= now;
                end
                else
                    busy_accum_reg <= busy_sum;
                chosen_fps_reg <= target_raw;
                throttle_time_reg <= now;
                deep_idle_reg <= deep_c;
            end
            if (cmd.thr_fin)
            begin
                soft_budget_reg <= soft_q;
                soft_phase_reg <= soft_q > hard_q;
            end
            if (cmd.nap && soft_phase_reg
                && (elapsed >= {22'd0, soft_budget_reg} || beat_reg.event_pending))
                soft_phase_reg <= 1'b0;
        end
    end

    // Beat capture, work registers and result.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            beat_reg <= in_data;
            action_reg <= ACT_NONE;
            sleep_reg <= '0;
        end
        if (cmd.thr_prep)
        begin
            base_reg <= base_c;
            target_reg <= target_raw;
            deep_reg <= deep_c;
        end
        if (cmd.thr_fin)
        begin
            if ({22'd0, hard_q} > elapsed)
            begin
                action_reg <= ACT_SLEEP;
                sleep_reg <= hard_q - elapsed[9:0];
            end
        end
        if (cmd.nap)
        begin
            if (!soft_phase_reg || elapsed >= {22'd0, soft_budget_reg}
                || beat_reg.event_pending)
                action_reg <= ACT_DONE;
            else
            begin
                action_reg <= ACT_SLEEP;
                sleep_reg <= nap_sleep;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.action <= action_reg;
            out_reg.sleep_ms <= sleep_reg;
            out_reg.target_fps <= chosen_fps_reg;
            out_reg.busy_per_sec <= busy_last_reg;
        end
    end

    assign out_data = out_reg;

    // Deep idle is chosen only with its fixed rate.
    a_deep_rate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.thr_fin && deep_reg |-> target_reg == DEEP_IDLE_FPS)
        else $error("deep idle without deep idle rate");
    // Budgets never divide by zero.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (base_reg != 10'd0 && target_reg != 10'd0))
        else $error("zero rate reached the divider");
    // Soft phase is armed only by a throttle completion.
    a_soft_arm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(soft_phase_reg) |-> $past(cmd.thr_fin))
        else $error("soft phase armed outside throttle");
endmodule
`default_nettype wire

@@ design/adaptive_frame_pacer_unit.sv @@
`default_nettype none
// Adaptive frame pacer. Each input beat carries a command and a millisecond
// timestamp and yields exactly one result beat. Mark, activity, present,
// nap check and unknown commands go from dispatch straight to the result;
// throttle begin first chooses the rates and then runs two bit-serial
// dividers that form 1000/base and 1000/target one quotient bit a cycle.
// One beat is in work at a time; the output register lets the next beat
// enter while a result waits.
// Configuration registers at byte addresses 0, 4, 8, 12: nominal_fps,
// fps_cap, idle_fps, idle_grace_ms; write them only while the block is idle.
module adaptive_frame_pacer_unit
    import afp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire afp_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output afp_out_t         out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    afp_cfg_t  cfg_reg;
    afp_cmd_t  cmd;
    afp_stat_t stat;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    // Register file write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nominal_fps <= 10'd60;
            cfg_reg.fps_cap <= 10'd1000;
            cfg_reg.idle_fps <= 10'd15;
            cfg_reg.idle_grace_ms <= 16'd400;
        end
        else if (wr_en && paddr[1:0] == 2'd0)
        begin
            case (paddr[3:2])
                REG_NOMINAL: cfg_reg.nominal_fps <= pwdata[9:0];
                REG_CAP:     cfg_reg.fps_cap <= pwdata[9:0];
                REG_IDLE:    cfg_reg.idle_fps <= pwdata[9:0];
                REG_GRACE:   cfg_reg.idle_grace_ms <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // Register read.
    always_comb
    begin
        case (paddr[3:2])
            REG_NOMINAL: prdata = {22'd0, cfg_reg.nominal_fps};
            REG_CAP:     prdata = {22'd0, cfg_reg.fps_cap};
            REG_IDLE:    prdata = {22'd0, cfg_reg.idle_fps};
            REG_GRACE:   prdata = {16'd0, cfg_reg.idle_grace_ms};
            default:     prdata = '0;
        endcase
    end

    afp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_stall(out_stall), .out_valid(out_valid), .stat(stat), .cmd(cmd)
    );

    afp_dp u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg(cfg_reg),
        .cmd(cmd), .stat(stat), .out_data(out_data)
    );
endmodule
`default_nettype wire
